[rtl/afrx_pkg.sv]
// Package: shared constants and result type for the API frame receive deframer.
`timescale 1ns / 1ps

package afrx_pkg;

    localparam logic [7:0]  DELIM_BYTE     = 8'h7E;
    localparam logic [7:0]  RX_PACKET_TYPE = 8'h90;
    // RF data begins at frame offset 15, i.e. frame data byte 12
    localparam logic [15:0] RF_DATA_INDEX  = 16'd12;
    localparam logic [15:0] ERR_MAX        = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_CSUM_BAD   = 2'd1,
        ST_TOO_SHORT  = 2'd2,
        ST_EMPTY      = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  frame_type;
        logic [1:0]  frame_status;
        logic [15:0] error_count;
        logic        last;
    } afrx_result_t;

endpackage

[rtl/afrx_if.sv]
// Interfaces: received byte channel and deframed result channel.
`timescale 1ns / 1ps

interface afrx_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afrx_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [1:0]  frame_status;
    logic [15:0] error_count;
    logic        last;

    modport source (output valid, output payload_byte, output frame_type,
                    output frame_status, output error_count, output last,
                    input ready);
    modport sink   (input valid, input payload_byte, input frame_type,
                    input frame_status, input error_count, input last,
                    output ready);
endinterface

[rtl/afrx_out_buf.sv]
// Two-entry output buffer with registered ready, decouples result beats from the sink.
`timescale 1ns / 1ps

module afrx_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  afrx_pkg::afrx_result_t push_data,
    output logic                  can_push,
    afrx_frame_if.source          frame
);
    import afrx_pkg::*;

    afrx_result_t slot0_reg, slot0_next;
    afrx_result_t slot1_reg, slot1_next;
    logic [1:0]   count_reg, count_next;
    logic         pop;

    assign pop      = frame.valid && frame.ready;
    assign can_push = (count_reg != 2'd2);

    assign frame.valid        = (count_reg != 2'd0);
    assign frame.payload_byte = slot0_reg.payload_byte;
    assign frame.frame_type   = slot0_reg.frame_type;
    assign frame.frame_status = slot0_reg.frame_status;
    assign frame.error_count  = slot0_reg.error_count;
    assign frame.last         = slot0_reg.last;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        if (push)
        begin
            // write lands at the first free slot after any pop
            if (count_next == 2'd0)
                slot0_next = push_data;
            else
                slot1_next = push_data;
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

[rtl/api_frame_rx_deframer_top.sv]
// Top level: API frame receive deframer (delimiter hunt, length, checksum, RF data forwarding).
`timescale 1ns / 1ps

// A result beat passes from the input register into the two-entry output buffer
//   and is offered to the sink from there.
// Throughput: one byte per cycle; the input register and the per-byte phase
//   update stall only when the output buffer holds two unread beats.
// Reset (rst_n, async, active low): hunting for the delimiter, counters and
//   running sum cleared, both pipeline stages empty.
module api_frame_rx_deframer_top (
    input  logic         clk,
    input  logic         rst_n,
    afrx_rx_if.sink      rx,
    afrx_frame_if.source frame
);
    import afrx_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CSUM   = 3'd4
    } phase_t;

    // Input register stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state
    phase_t      phase_reg, phase_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] byte_index_reg, byte_index_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  type_seen_reg, type_seen_next;
    logic [15:0] error_total_reg, error_total_next;

    logic         emit;
    afrx_result_t result;
    logic         buf_can_push;
    logic         fire;

    logic [7:0]   b;
    logic [7:0]   type_eff;
    logic [15:0]  idx_inc;
    logic [15:0]  err_inc;
    logic         csum_bad;

    assign b       = in_byte_reg;
    assign idx_inc = byte_index_reg + 16'd1;
    assign err_inc = (error_total_reg == ERR_MAX) ? error_total_reg
                                                  : error_total_reg + 16'd1;
    // first data byte is the frame type
    assign type_eff = (byte_index_reg == 16'd0) ? b : type_seen_reg;
    // checksum byte must equal 0xFF minus the sum, i.e. its complement
    assign csum_bad = (b != ~running_sum_reg);

    // The byte in the input register is consumed when it makes no result or
    // the buffer has room for the result.
    assign fire     = in_valid_reg && (!emit || buf_can_push);
    assign rx.ready = !in_valid_reg || fire;

    always_comb
    begin
        phase_next        = phase_reg;
        length_high_next  = length_high_reg;
        frame_length_next = frame_length_reg;
        byte_index_next   = byte_index_reg;
        running_sum_next  = running_sum_reg;
        type_seen_next    = type_seen_reg;
        error_total_next  = error_total_reg;
        emit              = 1'b0;
        result            = '0;

        unique case (phase_reg)
            PH_LEN_HI:
            begin
                length_high_next = b;
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_length_next = {length_high_reg, b};
                byte_index_next   = 16'd0;
                running_sum_next  = 8'd0;
                type_seen_next    = 8'd0;
                phase_next        = ({length_high_reg, b} == 16'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA:
            begin
                running_sum_next = running_sum_reg + b;
                type_seen_next   = type_eff;
                byte_index_next  = idx_inc;
                if (idx_inc >= frame_length_reg)
                    phase_next = PH_CSUM;
                if (type_eff == RX_PACKET_TYPE && byte_index_reg >= RF_DATA_INDEX)
                begin
                    emit                = 1'b1;
                    result.payload_byte = b;
                    result.frame_type   = type_eff;
                    result.frame_status = ST_OK;
                    result.error_count  = error_total_reg;
                    result.last         = 1'b0;
                end
            end
            PH_CSUM:
            begin
                emit                = 1'b1;
                result.payload_byte = 8'd0;
                result.frame_type   = (frame_length_reg == 16'd0) ? 8'd0 : type_seen_reg;
                result.last         = 1'b1;
                if (csum_bad)
                begin
                    result.frame_status = ST_CSUM_BAD;
                    error_total_next    = err_inc;
                end
                else if (frame_length_reg == 16'd0)
                begin
                    result.frame_status = ST_EMPTY;
                end
                else if (type_seen_reg == RX_PACKET_TYPE && frame_length_reg < RF_DATA_INDEX)
                begin
                    result.frame_status = ST_TOO_SHORT;
                    error_total_next    = err_inc;
                end
                else
                begin
                    result.frame_status = ST_OK;
                end
                result.error_count = error_total_next;
                phase_next         = PH_HUNT;
            end
            default:
            begin
                // hunting; a delimiter inside a frame is ordinary data
                phase_next = (b == DELIM_BYTE) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_HUNT;
            length_high_reg  <= 8'd0;
            frame_length_reg <= 16'd0;
            byte_index_reg   <= 16'd0;
            running_sum_reg  <= 8'd0;
            type_seen_reg    <= 8'd0;
            error_total_reg  <= 16'd0;
        end
        else
        begin
            if (rx.ready)
                in_valid_reg <= rx.valid;
            if (fire)
            begin
                phase_reg        <= phase_next;
                length_high_reg  <= length_high_next;
                frame_length_reg <= frame_length_next;
                byte_index_reg   <= byte_index_next;
                running_sum_reg  <= running_sum_next;
                type_seen_reg    <= type_seen_next;
                error_total_reg  <= error_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            in_byte_reg <= rx.rx_byte;
    end

    afrx_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && emit),
        .push_data (result),
        .can_push  (buf_can_push),
        .frame     (frame)
    );

endmodule

[dv/tb_api_frame_rx_deframer_top.sv]
// Testbench: API frame receive deframer, byte stream against a cycle-free predictor.
`timescale 1ns / 1ps

module tb_api_frame_rx_deframer_top;
    import afrx_pkg::*;

    // Generous bound: the random part with its longest stalls fits well below it
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_BYTES = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Deframer phases, mirrored from the block's behavior
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CSUM   = 3'd4
    } rx_phase_t;

    // One row of the directed table: byte to send and, where it closes a frame,
    // the end beat spelled out by hand
    typedef struct packed {
        logic [7:0]   rx_byte;
        logic         has_beat;
        afrx_result_t beat;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // noise while hunting: dropped silently
        '{8'h55, 1'b0, '0},
        // empty frame, good checksum: status empty, type 0, no error
        '{DELIM_BYTE, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, '{8'h00, 8'h00, ST_EMPTY, 16'd0, 1'b1}},
        // empty frame, bad checksum: mismatch wins over empty
        '{DELIM_BYTE, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, 8'h00, ST_CSUM_BAD, 16'd1, 1'b1}},
        // receive packet with one data byte, good checksum: too short
        '{DELIM_BYTE, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{RX_PACKET_TYPE, 1'b0, '0},
        '{8'h6F, 1'b1, '{8'h00, RX_PACKET_TYPE, ST_TOO_SHORT, 16'd2, 1'b1}},
        // same short packet, bad checksum: mismatch has priority
        '{DELIM_BYTE, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{RX_PACKET_TYPE, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, RX_PACKET_TYPE, ST_CSUM_BAD, 16'd3, 1'b1}},
        // delimiter value as frame type inside a frame: plain data, status ok
        '{DELIM_BYTE, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{DELIM_BYTE, 1'b0, '0},
        '{8'h81, 1'b1, '{8'h00, DELIM_BYTE, ST_OK, 16'd3, 1'b1}}
    };

    logic clk;
    logic rst_n;

    afrx_rx_if    rx_if ();
    afrx_frame_if fr_if ();

    api_frame_rx_deframer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frame (fr_if)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------------
    // Predictor state: what the deframer should hold after each byte
    // ---------------------------------------------------------------------
    rx_phase_t   deframe_phase;
    logic [7:0]  hdr_len_hi;
    logic [15:0] frame_len;
    logic [15:0] data_idx;
    logic [7:0]  data_sum;
    logic [7:0]  frame_kind;
    logic [15:0] err_tally;

    afrx_result_t frame_beats_due [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  random_bytes;
    int  stall_left     = 0;
    int  sink_roll;
    bit  gaps_on;
    bit  sink_calm      = 1'b0;

    // Advances the predictor by one accepted byte; returns 1 when a beat is due
    function automatic bit deframe_byte(input logic [7:0] b, output afrx_result_t beat);
        logic [15:0] idx;
        logic [7:0]  want_csum;
        logic [1:0]  status;
        beat = '0;
        deframe_byte = 1'b0;
        case (deframe_phase)
            PH_LEN_HI:
            begin
                hdr_len_hi    = b;
                deframe_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_len     = {hdr_len_hi, b};
                data_idx      = '0;
                data_sum      = '0;
                frame_kind    = '0;
                deframe_phase = (frame_len == 16'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA:
            begin
                idx      = data_idx;
                data_sum = data_sum + b;
                if (idx == 16'd0)
                    frame_kind = b;
                data_idx = idx + 16'd1;
                if (data_idx >= frame_len)
                    deframe_phase = PH_CSUM;
                // RF data of a receive packet goes out as it arrives
                if (frame_kind == RX_PACKET_TYPE && idx >= RF_DATA_INDEX)
                begin
                    beat.payload_byte = b;
                    beat.frame_type   = frame_kind;
                    beat.frame_status = ST_OK;
                    beat.error_count  = err_tally;
                    beat.last         = 1'b0;
                    deframe_byte      = 1'b1;
                end
            end
            PH_CSUM:
            begin
                want_csum = 8'hFF - data_sum;
                if (b != want_csum)
                begin
                    status = ST_CSUM_BAD;
                    if (err_tally != ERR_MAX)
                        err_tally = err_tally + 16'd1;
                end
                else if (frame_len == 16'd0)
                    status = ST_EMPTY;
                else if (frame_kind == RX_PACKET_TYPE && frame_len < RF_DATA_INDEX)
                begin
                    status = ST_TOO_SHORT;
                    if (err_tally != ERR_MAX)
                        err_tally = err_tally + 16'd1;
                end
                else
                    status = ST_OK;
                beat.payload_byte = 8'h00;
                beat.frame_type   = (frame_len == 16'd0) ? 8'h00 : frame_kind;
                beat.frame_status = status;
                beat.error_count  = err_tally;
                beat.last         = 1'b1;
                deframe_byte      = 1'b1;
                deframe_phase     = PH_HUNT;
            end
            default:
                deframe_phase = (b == DELIM_BYTE) ? PH_LEN_HI : PH_HUNT;
        endcase
    endfunction

    // Mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void report_mismatch(input string what, input afrx_result_t want,
                                            input afrx_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: exp payload=%02h type=%02h status=%0d errs=%0d last=%0b",
                     what, want.payload_byte, want.frame_type, want.frame_status,
                     want.error_count, want.last);
        if (mismatch_count <= 10)
            $display("         got payload=%02h type=%02h status=%0d errs=%0d last=%0b",
                     got.payload_byte, got.frame_type, got.frame_status,
                     got.error_count, got.last);
    endfunction

    // Sends one byte, waits for the handshake, then books the predicted beat.
    // A typed beat from the directed table takes the place of the prediction.
    task automatic send_byte(input logic [7:0] b, input bit typed, input afrx_result_t typed_beat);
        int           gap;
        afrx_result_t beat;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        if (deframe_byte(b, beat) || typed)
            frame_beats_due = {frame_beats_due, (typed ? typed_beat : beat)};
    endtask

    // One frame with random content; mostly well formed receive packets,
    // the rest other types, empty frames, bad checksums and leading noise
    task automatic send_random_frame();
        logic [7:0] body [$];
        logic [7:0] kind;
        logic [7:0] sum;
        logic [7:0] csum;
        logic [7:0] junk;
        int         len;
        int         roll;
        int         n_noise;
        kind = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            kind = RX_PACKET_TYPE;
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 11) : $urandom_range(12, 28);
        end
        else if (roll < 75)
            len = 0;
        else
            len = $urandom_range(1, 16);
        // now and then a long frame
        if ($urandom_range(0, 49) == 0)
            len = $urandom_range(100, 300);
        sum = 8'h00;
        for (int i = 0; i < len; i++)
        begin
            body = {body, ((i == 0) ? kind : 8'($urandom_range(0, 255)))};
            sum = sum + body[i];
        end
        csum = 8'hFF - sum;
        if ($urandom_range(0, 99) < 15)
            csum = csum ^ 8'($urandom_range(1, 255));
        gaps_on = ($urandom_range(0, 7) != 0);
        // noise between frames, kept clear of the delimiter so it stays noise
        n_noise = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        for (int i = 0; i < n_noise; i++)
        begin
            junk = 8'($urandom_range(0, 255));
            if (junk == DELIM_BYTE)
                junk = ~junk;
            send_byte(junk, 1'b0, '0);
        end
        send_byte(DELIM_BYTE, 1'b0, '0);
        send_byte(8'(len >> 8), 1'b0, '0);
        send_byte(8'(len), 1'b0, '0);
        foreach (body[i])
            send_byte(body[i], 1'b0, '0);
        send_byte(csum, 1'b0, '0);
        random_bytes += len + 4;
    endtask

    // ---------------------------------------------------------------------
    // Result side: check each beat and drive ready with random stalls
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && fr_if.valid && fr_if.ready)
        begin : check_beat
            afrx_result_t got;
            afrx_result_t want;
            got.payload_byte = fr_if.payload_byte;
            got.frame_type   = fr_if.frame_type;
            got.frame_status = fr_if.frame_status;
            got.error_count  = fr_if.error_count;
            got.last         = fr_if.last;
            if (frame_beats_due.size() == 0)
                report_mismatch("beat with nothing pending", '0, got);
            else
            begin
                want = frame_beats_due.pop_front();
                if (got.payload_byte !== want.payload_byte ||
                    got.frame_type   !== want.frame_type   ||
                    got.frame_status !== want.frame_status ||
                    got.error_count  !== want.error_count  ||
                    got.last         !== want.last)
                    report_mismatch("beat fields", want, got);
            end
        end
        // calm stretches come and go on their own
        if ($urandom_range(0, 299) == 0)
            sink_calm = !sink_calm;
        if (stall_left > 0)
        begin
            stall_left--;
            fr_if.ready <= 1'b0;
        end
        else
        begin
            sink_roll = $urandom_range(0, 99);
            if (sink_calm || sink_roll < 70)
                fr_if.ready <= 1'b1;
            else
            begin
                fr_if.ready <= 1'b0;
                stall_left = (sink_roll < 95) ? $urandom_range(0, 2) : $urandom_range(3, 30);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = 8'h00;
        random_bytes   = 0;
        gaps_on        = 1'b1;

        // predictor starts where reset leaves the block
        deframe_phase = PH_HUNT;
        hdr_len_hi    = '0;
        frame_len     = '0;
        data_idx      = '0;
        data_sum      = '0;
        frame_kind    = '0;
        err_tally     = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty frames, checksum and too-short errors, delimiter as data
        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TABLE[i].rx_byte, DIR_TABLE[i].has_beat, DIR_TABLE[i].beat);

        // random frames
        while (random_bytes < RANDOM_BYTES)
            send_random_frame();
        rx_if.valid <= 1'b0;

        while (frame_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/afrx_pkg.sv
rtl/afrx_if.sv
rtl/afrx_out_buf.sv
rtl/api_frame_rx_deframer_top.sv
dv/tb_api_frame_rx_deframer_top.sv
